[rtl/core/prq_pkg.sv]
// shared types and constants of the priority request queue
package prq_pkg;

   localparam int PRIO_WIDTH  = 16;
   localparam int COUNT_WIDTH = 5;
   localparam int STATUS_WIDTH = 2;
   localparam int DEFAULT_DEPTH = 16;
   localparam int DEFAULT_TAG_WIDTH = 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_cmd_type;

endpackage

[rtl/core/prq_cell.sv]
// one slot of the sorted chain: holds an entry and trades it with its neighbours
module prq_cell
   import prq_pkg::*;
#(
   parameter int TAG_WIDTH = DEFAULT_TAG_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [PRIO_WIDTH-1:0] new_prio,
   input  logic [TAG_WIDTH-1:0]  new_tag,
   input  logic                  prev_valid,
   input  logic                  prev_lower,
   input  logic [PRIO_WIDTH-1:0] prev_prio,
   input  logic [TAG_WIDTH-1:0]  prev_tag,
   input  logic                  next_valid,
   input  logic [PRIO_WIDTH-1:0] next_prio,
   input  logic [TAG_WIDTH-1:0]  next_tag,
   output logic                  valid,
   output logic                  lower,
   output logic [PRIO_WIDTH-1:0] prio,
   output logic [TAG_WIDTH-1:0]  tag
);

   logic                  valid_ff, valid_in;
   logic [PRIO_WIDTH-1:0] prio_ff, prio_in;
   logic [TAG_WIDTH-1:0]  tag_ff, tag_in;

   // free slot or strictly lower entry: the new request goes here or above
   assign lower = !valid_ff || (prio_ff < new_prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      if (cmd.insert) begin
         valid_in = valid_ff | prev_valid;
         if (lower) begin
            if (prev_lower) begin
               prio_in = prev_prio;
               tag_in  = prev_tag;
            end else begin
               prio_in = new_prio;
               tag_in  = new_tag;
            end
         end
      end else if (cmd.pop) begin
         valid_in = next_valid;
         prio_in  = next_prio;
         tag_in   = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign tag   = tag_ff;

endmodule

[rtl/core/priority_request_queue_top.sv]
// top level of the priority request queue: chain of sorted cells and result register
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | op, priority_req, tag
//  rsp_    | out       | rsp_valid / rsp_ready | status, out_tag, out_priority, count
//
// one beat per cycle while the result is not stalled: every cell compares and shifts in the same cycle,
// so an insert or pop updates the chain and registers its result together
// the single result register sets the pace: a new beat is taken while the
// held result leaves, or whenever the register is empty
// synchronous reset empties the chain and drops any held result at once
// a stalled result holds req_ready low until it is taken
module priority_request_queue_top
   import prq_pkg::*;
#(
   parameter int DEPTH     = DEFAULT_DEPTH,
   parameter int TAG_WIDTH = DEFAULT_TAG_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic [PRIO_WIDTH-1:0]   req_priority_req,
   input  logic [TAG_WIDTH-1:0]    req_tag,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [TAG_WIDTH-1:0]    rsp_out_tag,
   output logic [PRIO_WIDTH-1:0]   rsp_out_priority,
   output logic [COUNT_WIDTH-1:0]  rsp_count
);

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   // per-cell taps, slot 0 is the head
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_lower;
   logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
   logic [TAG_WIDTH-1:0]  cell_tag  [DEPTH];

   cell_cmd_type cmd;
   logic         accept;
   logic         is_insert;
   logic         full;
   logic         empty;

   logic [CNT_WIDTH-1:0] held_count_ff, held_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [TAG_WIDTH-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [PRIO_WIDTH-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // count reported in its low bits, zero-extended when the counter is narrower
   logic [CNT_WIDTH+COUNT_WIDTH-1:0] count_wide;

   // the result register frees itself in the cycle it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_insert = (op_type'(req_op) == OP_INSERT);

   // valid bits fill from the head, so the ends tell full and empty
   assign full  = cell_valid[DEPTH-1];
   assign empty = !cell_valid[0];

   assign cmd.insert = accept && is_insert && !full;
   assign cmd.pop    = accept && !is_insert && !empty;

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  prev_valid, prev_lower, next_valid;
      logic [PRIO_WIDTH-1:0] prev_prio, next_prio;
      logic [TAG_WIDTH-1:0]  prev_tag, next_tag;

      if (i == 0) begin : g_head
         // the head always takes the new request when it is the highest
         assign prev_valid = 1'b1;
         assign prev_lower = 1'b0;
         assign prev_prio  = '0;
         assign prev_tag   = '0;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
         assign prev_lower = cell_lower[i-1];
         assign prev_prio  = cell_prio[i-1];
         assign prev_tag   = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // a pop empties the last slot
         assign next_valid = 1'b0;
         assign next_prio  = '0;
         assign next_tag   = '0;
      end else begin : g_link
         assign next_valid = cell_valid[i+1];
         assign next_prio  = cell_prio[i+1];
         assign next_tag   = cell_tag[i+1];
      end

      prq_cell #(
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_prio   (req_priority_req),
         .new_tag    (req_tag),
         .prev_valid (prev_valid),
         .prev_lower (prev_lower),
         .prev_prio  (prev_prio),
         .prev_tag   (prev_tag),
         .next_valid (next_valid),
         .next_prio  (next_prio),
         .next_tag   (next_tag),
         .valid      (cell_valid[i]),
         .lower      (cell_lower[i]),
         .prio       (cell_prio[i]),
         .tag        (cell_tag[i])
      );
   end

   // occupancy counter
   always_comb begin
      held_count_in = held_count_ff;
      if (cmd.insert) begin
         held_count_in = held_count_ff + CNT_WIDTH'(1);
      end else if (cmd.pop) begin
         held_count_in = held_count_ff - CNT_WIDTH'(1);
      end
   end

   assign count_wide = {{COUNT_WIDTH{1'b0}}, held_count_in};

   // result of the accepted beat: tag and priority from the state before the update, count after it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_tag_in    = '0;
         rsp_prio_in   = '0;
         rsp_count_in  = count_wide[COUNT_WIDTH-1:0];
         if (is_insert) begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end
         end else if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            // head leaves
            rsp_tag_in  = cell_tag[0];
            rsp_prio_in = cell_prio[0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_count_ff <= held_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_count        = rsp_count_ff;

   // valid cells always form an unbroken run from the head
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid & (cell_valid + DEPTH'(1))) == '0))
      else $error("valid cells not contiguous from the head");

   // counter agrees with the occupied cells
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == CNT_WIDTH'($countones(cell_valid))))
      else $error("occupancy counter out of step with cells");

   // a pop on an empty queue reports empty and leaves the count at zero
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_insert && empty) |=>
         (rsp_status_ff == ST_EMPTY && held_count_ff == '0))
      else $error("pop on empty queue misreported");

   // a dropped insert leaves the valid bits and the occupancy counter untouched
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && is_insert && full) |=>
         (rsp_status_ff == ST_FULL && $stable(cell_valid) && $stable(held_count_ff)))
      else $error("insert into full queue changed the chain");

   // every accepted beat leaves a result behind
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

endmodule
